### src/rsi_pkg.sv
package rsi_pkg;

  localparam int MinParamW = 17;
  localparam logic [MinParamW-1:0] MinParamRst = 17'd1;

  // quotient, divisor and numerator magnitude widths
  localparam int QW   = 63;
  localparam int DenW = 65;
  localparam int NumW = 66;
  localparam int DivStages = QW;

  localparam logic [QW-1:0] TClamp = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] edge_a_x;
    logic signed [31:0] edge_a_y;
    logic signed [31:0] edge_b_x;
    logic signed [31:0] edge_b_y;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
  } res_t;

  // item context carried alongside the arithmetic
  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [32:0] ddx;
    logic signed [32:0] ddy;
    logic [65:0]        len2;
    logic               miss;
  } side_t;

endpackage

### src/ray_segment_intersection.sv
// Ray against line segment test in 2D, all coordinates signed Q16.16. One
// transfer is accepted every cycle unless a result waits on res_ready, and
// each gives exactly one result, in order. The ray parameter divider
// resolves one quotient bit per stage over 63 stages. The whole pipeline
// holds when a result waits on res_ready, so nothing is lost or repeated. A
// parallel ray, a ray pointing away from the segment, a ray parameter below
// min_param (cfg_data, reset 2^-16) or a hit point outside the segment
// gives hit = 0 with a zero point; the hit point saturates to the 32-bit
// range. Write cfg only while the pipeline is empty.
module ray_segment_intersection (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               ray_valid,
  output logic                               ray_ready,
  input  rsi_pkg::ray_t                      ray,
  output logic                               res_valid,
  input  logic                               res_ready,
  output rsi_pkg::res_t                      res,
  input  logic                               cfg_we,
  input  logic [rsi_pkg::MinParamW-1:0]      cfg_data
);

  logic [rsi_pkg::MinParamW-1:0] min_param;
  logic adv;

  // advance everything when the output stage is free or being drained
  assign adv       = !res_valid || res_ready;
  assign ray_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_param <= rsi_pkg::MinParamRst;
    end else if (cfg_we) begin
      min_param <= cfg_data;
    end
  end

  // ---- stage 1: segment vector and origin offsets
  logic v1;
  rsi_pkg::ray_t r1;
  logic signed [32:0] ddx1, ddy1, wx1, wy1;

  always_ff @(posedge clk) begin
    if (adv) begin
      r1   <= ray;
      ddx1 <= 33'(ray.edge_b_x) - 33'(ray.edge_a_x);
      ddy1 <= 33'(ray.edge_b_y) - 33'(ray.edge_a_y);
      wx1  <= 33'(ray.ray_origin_x) - 33'(ray.edge_a_x);
      wy1  <= 33'(ray.ray_origin_y) - 33'(ray.edge_a_y);
    end
  end

  // ---- stage 2: cross and square products
  logic v2;
  rsi_pkg::ray_t r2;
  logic signed [32:0] ddx2, ddy2;
  logic signed [64:0] pa2, pb2;
  logic signed [65:0] pc2, pd2, pe2, pf2;

  always_ff @(posedge clk) begin
    if (adv) begin
      r2   <= r1;
      ddx2 <= ddx1;
      ddy2 <= ddy1;
      pa2  <= 65'(r1.ray_dir_x) * 65'(ddy1);
      pb2  <= 65'(r1.ray_dir_y) * 65'(ddx1);
      pc2  <= 66'(wy1) * 66'(ddx1);
      pd2  <= 66'(wx1) * 66'(ddy1);
      pe2  <= 66'(ddx1) * 66'(ddx1);
      pf2  <= 66'(ddy1) * 66'(ddy1);
    end
  end

  // ---- stage 3: denominator, numerator, squared length
  logic v3;
  rsi_pkg::ray_t r3;
  logic signed [32:0] ddx3, ddy3;
  logic signed [65:0] den3;
  logic signed [66:0] num3;
  logic [65:0] len3;

  always_ff @(posedge clk) begin
    if (adv) begin
      r3   <= r2;
      ddx3 <= ddx2;
      ddy3 <= ddy2;
      den3 <= 66'(pa2) - 66'(pb2);
      num3 <= 67'(pc2) - 67'(pd2);
      len3 <= 66'(pe2) + 66'(pf2);
    end
  end

  // ---- parallel and direction checks, magnitudes into the divider
  rsi_pkg::side_t side4;
  logic signed [66:0] nneg4;
  logic signed [65:0] dneg4;
  logic [rsi_pkg::NumW-1:0] nmag4;
  logic [rsi_pkg::DenW-1:0] dmag4;

  always_comb begin
    nneg4 = -num3;
    dneg4 = -den3;
    nmag4 = num3[66] ? nneg4[rsi_pkg::NumW-1:0] : num3[rsi_pkg::NumW-1:0];
    dmag4 = den3[65] ? dneg4[rsi_pkg::DenW-1:0] : den3[rsi_pkg::DenW-1:0];
    side4.ex   = r3.ray_origin_x;
    side4.ey   = r3.ray_origin_y;
    side4.dx   = r3.ray_dir_x;
    side4.dy   = r3.ray_dir_y;
    side4.ax   = r3.edge_a_x;
    side4.ay   = r3.edge_a_y;
    side4.ddx  = ddx3;
    side4.ddy  = ddy3;
    side4.len2 = len3;
    // parallel, or intersection behind the origin
    side4.miss = (den3 == '0) || ((num3 != '0) && (num3[66] != den3[65]));
  end

  logic dv;
  rsi_pkg::side_t dside;
  logic [rsi_pkg::QW-1:0] dq;
  logic dovf;

  rsi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v3),
    .in_side   (side4),
    .num       (nmag4),
    .den       (dmag4),
    .out_valid (dv),
    .out_side  (dside),
    .out_q     (dq),
    .out_ovf   (dovf)
  );

  // ---- stage 5: clamp t, minimum test, direction magnitudes
  logic v5;
  rsi_pkg::side_t side5, sd5;
  logic [rsi_pkg::QW-1:0] t_c, t5;
  logic [31:0] mdx5, mdy5;

  assign t_c = (dovf || (dq > rsi_pkg::TClamp)) ? rsi_pkg::TClamp : dq;

  always_comb begin
    side5      = dside;
    side5.miss = dside.miss ||
                 (t_c < {{(rsi_pkg::QW-rsi_pkg::MinParamW){1'b0}}, min_param});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd5      <= side5;
      t5       <= t_c;
      mdx5     <= dside.dx[31] ? 32'(-dside.dx) : 32'(dside.dx);
      mdy5     <= dside.dy[31] ? 32'(-dside.dy) : 32'(dside.dy);
    end
  end

  // ---- stage 6: partial products of |d| * t
  logic v6;
  rsi_pkg::side_t sd6;
  logic [63:0] xl6, xh6, yl6, yh6;

  always_ff @(posedge clk) begin
    if (adv) begin
      sd6 <= sd5;
      xl6 <= 64'(mdx5) * 64'(t5[31:0]);
      xh6 <= 64'(mdx5) * 64'(t5[62:32]);
      yl6 <= 64'(mdy5) * 64'(t5[31:0]);
      yh6 <= 64'(mdy5) * 64'(t5[62:32]);
    end
  end

  // ---- stage 7: combine partials, drop the fraction
  logic v7;
  rsi_pkg::side_t sd7;
  logic [94:0] px_full, py_full;
  logic [78:0] mx7, my7;

  assign px_full = 95'(xl6) + {xh6[62:0], 32'b0};
  assign py_full = 95'(yl6) + {yh6[62:0], 32'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      sd7 <= sd6;
      mx7 <= px_full[94:16];
      my7 <= py_full[94:16];
    end
  end

  // ---- stage 8: move from origin and saturate
  logic v8;
  rsi_pkg::side_t sd8;
  logic signed [31:0] px8, py8;
  logic signed [80:0] sx, sy;

  function automatic logic signed [31:0] sat32(input logic signed [80:0] s);
    logic signed [31:0] o;
    if (!s[80] && (|s[79:31])) begin
      o = 32'sh7FFF_FFFF;
    end else if (s[80] && !(&s[79:31])) begin
      o = 32'sh8000_0000;
    end else begin
      o = s[31:0];
    end
    return o;
  endfunction

  always_comb begin
    sx = sd7.dx[31] ? (81'(sd7.ex) - 81'(signed'({2'b0, mx7})))
                    : (81'(sd7.ex) + 81'(signed'({2'b0, mx7})));
    sy = sd7.dy[31] ? (81'(sd7.ey) - 81'(signed'({2'b0, my7})))
                    : (81'(sd7.ey) + 81'(signed'({2'b0, my7})));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd8 <= sd7;
      px8 <= sat32(sx);
      py8 <= sat32(sy);
    end
  end

  // ---- stage 9: hit point relative to the first endpoint
  logic v9;
  rsi_pkg::side_t sd9;
  logic signed [31:0] px9, py9;
  logic signed [32:0] qx9, qy9;

  always_ff @(posedge clk) begin
    if (adv) begin
      sd9 <= sd8;
      px9 <= px8;
      py9 <= py8;
      qx9 <= 33'(px8) - 33'(sd8.ax);
      qy9 <= 33'(py8) - 33'(sd8.ay);
    end
  end

  // ---- stage 10: projection products
  logic v10;
  rsi_pkg::side_t sd10;
  logic signed [31:0] px10, py10;
  logic signed [65:0] gx10, gy10;

  always_ff @(posedge clk) begin
    if (adv) begin
      sd10 <= sd9;
      px10 <= px9;
      py10 <= py9;
      gx10 <= 66'(sd9.ddx) * 66'(qx9);
      gy10 <= 66'(sd9.ddy) * 66'(qy9);
    end
  end

  // ---- stage 11: dot product
  logic v11;
  rsi_pkg::side_t sd11;
  logic signed [31:0] px11, py11;
  logic signed [66:0] dot11;

  always_ff @(posedge clk) begin
    if (adv) begin
      sd11  <= sd10;
      px11  <= px10;
      py11  <= py10;
      dot11 <= 67'(gx10) + 67'(gy10);
    end
  end

  // ---- stage 12: segment bound test, output register
  logic hit_c;

  assign hit_c = !sd11.miss && !dot11[66] && !(dot11[65:0] > sd11.len2);

  always_ff @(posedge clk) begin
    if (adv) begin
      res.hit     <= hit_c;
      res.cross_x <= hit_c ? px11 : '0;
      res.cross_y <= hit_c ? py11 : '0;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1 <= ray_valid; v2 <= v1; v3 <= v2; v5 <= dv; v6 <= v5;
      v7 <= v6; v8 <= v7; v9 <= v8; v10 <= v9; v11 <= v10;
      res_valid <= v11;
    end
  end

endmodule

### src/rsi_div.sv
module rsi_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  rsi_pkg::side_t                 in_side,
  input  logic [rsi_pkg::NumW-1:0]       num,
  input  logic [rsi_pkg::DenW-1:0]       den,
  output logic                           out_valid,
  output rsi_pkg::side_t                 out_side,
  output logic [rsi_pkg::QW-1:0]         out_q,
  output logic                           out_ovf
);

  localparam int S = rsi_pkg::DivStages;

  logic [S:0]                   v;
  logic [rsi_pkg::DenW-1:0]     r   [0:S];
  logic [rsi_pkg::QW-1:0]       nl  [0:S];
  logic [rsi_pkg::QW-1:0]       q   [0:S];
  logic [rsi_pkg::DenW-1:0]     dn  [0:S];
  logic                         ov  [0:S];
  rsi_pkg::side_t               sd  [0:S];

  logic [rsi_pkg::DenW:0]       rr  [0:S-1];
  logic [rsi_pkg::DenW:0]       rs  [0:S-1];
  logic                         ge  [0:S-1];

  always_comb begin
    for (int k = 0; k < S; k++) begin
      rr[k] = {r[k], nl[k][rsi_pkg::QW-1]};
      ge[k] = rr[k] >= {1'b0, dn[k]};
      rs[k] = ge[k] ? (rr[k] - {1'b0, dn[k]}) : rr[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[S-1:0], in_valid};
    end
  end

  // entry stage: top numerator bits against the divisor flag quotient overflow
  always_ff @(posedge clk) begin
    if (adv) begin
      r[0]  <= {{(rsi_pkg::DenW-19){1'b0}}, num[65:47]};
      nl[0] <= {num[46:0], 16'b0};
      q[0]  <= '0;
      dn[0] <= den;
      ov[0] <= {{(rsi_pkg::DenW-19){1'b0}}, num[65:47]} >= den;
      sd[0] <= in_side;
      for (int k = 0; k < S; k++) begin
        r[k+1]  <= rs[k][rsi_pkg::DenW-1:0];
        nl[k+1] <= {nl[k][rsi_pkg::QW-2:0], 1'b0};
        q[k+1]  <= {q[k][rsi_pkg::QW-2:0], ge[k]};
        dn[k+1] <= dn[k];
        ov[k+1] <= ov[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = v[S];
  assign out_side  = sd[S];
  assign out_q     = q[S];
  assign out_ovf   = ov[S];

endmodule
